// ----- rtl/euler_zyx_point_rotator_macros.svh -----
// ---------------------------------------------------------------------------
// Euler ZYX point rotator assertion macros
// Concurrent assertion forms for the rotator checker.
// ---------------------------------------------------------------------------
`ifndef EULER_ZYX_POINT_ROTATOR_MACROS_SVH
`define EULER_ZYX_POINT_ROTATOR_MACROS_SVH

// Assertion that is disabled while reset is high.
`define EZPR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rotator assertion failed");

// Assertion that is checked during reset as well.
`define EZPR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("rotator assertion failed");

`endif

// ----- rtl/ezpr_pkg.sv -----
// ---------------------------------------------------------------------------
// Euler ZYX point rotator package
// Types, constants and helper functions shared by the rotator modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ezpr_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int TABLE_LEN     = 24;
   localparam int NUM_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
   localparam int STAGE_IDX_W   = 5;
   localparam int COORD_W       = 24;
   localparam int TRIG_W        = 32;
   localparam int PHASE_W       = 33;
   localparam int ENTRY_W       = 33;

   localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 32'sd652032874;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

   typedef struct packed {
      logic signed [TRIG_W-1:0]  x;
      logic signed [TRIG_W-1:0]  y;
      logic signed [PHASE_W-1:0] z;
   } cordic_lane_type;

   typedef struct packed {
      cordic_lane_type [2:0]     lane;
      logic [2:0]                flip;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic signed [COORD_W-1:0] pz;
   } cordic_item_type;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] m00, m01, m02;
      logic signed [ENTRY_W-1:0] m10, m11, m12;
      logic signed [ENTRY_W-1:0] m20, m21, m22;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic signed [COORD_W-1:0] pz;
   } matrix_item_type;

   function automatic logic signed [PHASE_W-1:0] atan_turn(input logic [STAGE_IDX_W-1:0] i);
      logic signed [PHASE_W-1:0] a;
      case (i)
         5'd0:    a = 33'sh020000000;
         5'd1:    a = 33'sh012E4051E;
         5'd2:    a = 33'sh009FB385B;
         5'd3:    a = 33'sh0051111D4;
         5'd4:    a = 33'sh0028B0D43;
         5'd5:    a = 33'sh00145D7E1;
         5'd6:    a = 33'sh000A2F61E;
         5'd7:    a = 33'sh000517C55;
         5'd8:    a = 33'sh00028BE53;
         5'd9:    a = 33'sh000145F2F;
         5'd10:   a = 33'sh0000A2F98;
         5'd11:   a = 33'sh0000517CC;
         5'd12:   a = 33'sh000028BE6;
         5'd13:   a = 33'sh0000145F3;
         5'd14:   a = 33'sh00000A2FA;
         5'd15:   a = 33'sh00000517D;
         5'd16:   a = 33'sh0000028BE;
         5'd17:   a = 33'sh00000145F;
         5'd18:   a = 33'sh000000A30;
         5'd19:   a = 33'sh000000518;
         5'd20:   a = 33'sh00000028C;
         5'd21:   a = 33'sh000000146;
         5'd22:   a = 33'sh0000000A3;
         5'd23:   a = 33'sh000000051;
         default: a = '0;
      endcase
      return a;
   endfunction

   function automatic logic signed [ENTRY_W-1:0] round_q30(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd536870912;
      return t[62:30];
   endfunction

endpackage

// ----- rtl/euler_zyx_point_rotator.sv -----
// ---------------------------------------------------------------------------
// Euler ZYX point rotator
// Rotates one point per transaction by Rz(yaw) * Ry(pitch) * Rx(roll).
// ---------------------------------------------------------------------------
// Throughput: one transaction per cycle while rsp_ready is not held low; the
// input register, the CORDIC cell chain and the multiplier stages each hold
// one transaction and advance whenever the next stage can take it.
// Reset clears all valid flags; no state survives between transactions.
`timescale 1ns / 1ps

module euler_zyx_point_rotator import ezpr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic signed [COORD_W-1:0] req_point_z,
   input  logic signed [15:0]        req_yaw_angle,
   input  logic signed [15:0]        req_pitch_angle,
   input  logic signed [15:0]        req_roll_angle,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_rotated_x,
   output logic signed [COORD_W-1:0] rsp_rotated_y,
   output logic signed [COORD_W-1:0] rsp_rotated_z,
   output logic                      rsp_clipped
);

   logic            in_valid_ff;
   logic            in_rdy;
   cordic_item_type in_item_ff, in_item_in;
   logic [15:0]     angle [3];

   logic            chain_valid [NUM_STAGES+1];
   logic            chain_ready [NUM_STAGES+1];
   cordic_item_type chain_item  [NUM_STAGES+1];

   logic            mat_valid, mat_ready;
   matrix_item_type mat_item;

   logic               prod_valid_ff, prod_rdy;
   logic signed [56:0] prod_ff [9];
   logic signed [56:0] prod_in [9];
   logic               out_valid_ff, out_rdy;
   logic signed [58:0] sum [3];
   logic signed [58:0] sum_r [3];
   logic signed [28:0] rnd [3];
   logic signed [COORD_W-1:0] sat [3];
   logic [2:0]         clip;
   logic signed [COORD_W-1:0] rx_ff, ry_ff, rz_ff;
   logic               clip_ff;

   assign angle[0] = req_yaw_angle;
   assign angle[1] = req_pitch_angle;
   assign angle[2] = req_roll_angle;

   assign in_rdy    = !in_valid_ff || chain_ready[0];
   assign req_ready = in_rdy;

   always_comb begin
      in_item_in.px = req_point_x;
      in_item_in.py = req_point_y;
      in_item_in.pz = req_point_z;
      for (int l = 0; l < 3; l++) begin
         in_item_in.flip[l]   = angle[l][15] ^ angle[l][14];
         in_item_in.lane[l].x = GAIN_Q30;
         in_item_in.lane[l].y = '0;
         in_item_in.lane[l].z = {in_item_in.flip[l] ^ angle[l][15],
                                 in_item_in.flip[l] ^ angle[l][15],
                                 angle[l][14:0], 16'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_rdy) begin
         in_valid_ff <= req_valid;
      end
      if (in_rdy) begin
         in_item_ff <= in_item_in;
      end
   end

   assign chain_valid[0] = in_valid_ff;
   assign chain_item[0]  = in_item_ff;

   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_cell
      ezpr_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (STAGE_IDX_W'(k)),
         .in_valid  (chain_valid[k]),
         .in_item   (chain_item[k]),
         .in_ready  (chain_ready[k]),
         .out_valid (chain_valid[k+1]),
         .out_item  (chain_item[k+1]),
         .out_ready (chain_ready[k+1])
      );
   end

   ezpr_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[NUM_STAGES]),
      .in_item   (chain_item[NUM_STAGES]),
      .in_ready  (chain_ready[NUM_STAGES]),
      .out_valid (mat_valid),
      .out_item  (mat_item),
      .out_ready (mat_ready)
   );

   assign out_rdy   = !out_valid_ff || rsp_ready;
   assign prod_rdy  = !prod_valid_ff || out_rdy;
   assign mat_ready = prod_rdy;

   always_comb begin
      prod_in[0] = mat_item.m00 * mat_item.px;
      prod_in[1] = mat_item.m01 * mat_item.py;
      prod_in[2] = mat_item.m02 * mat_item.pz;
      prod_in[3] = mat_item.m10 * mat_item.px;
      prod_in[4] = mat_item.m11 * mat_item.py;
      prod_in[5] = mat_item.m12 * mat_item.pz;
      prod_in[6] = mat_item.m20 * mat_item.px;
      prod_in[7] = mat_item.m21 * mat_item.py;
      prod_in[8] = mat_item.m22 * mat_item.pz;
      for (int r = 0; r < 3; r++) begin
         sum[r]   = 59'(prod_ff[3*r]) + 59'(prod_ff[3*r+1]) + 59'(prod_ff[3*r+2]);
         sum_r[r] = sum[r] + 59'sd536870912;
         rnd[r]   = sum_r[r][58:30];
         if (rnd[r] > 29'(COORD_MAX)) begin
            sat[r]  = COORD_MAX;
            clip[r] = 1'b1;
         end else if (rnd[r] < 29'(COORD_MIN)) begin
            sat[r]  = COORD_MIN;
            clip[r] = 1'b1;
         end else begin
            sat[r]  = rnd[r][COORD_W-1:0];
            clip[r] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (prod_rdy) prod_valid_ff <= mat_valid;
         if (out_rdy) out_valid_ff <= prod_valid_ff;
      end
      if (prod_rdy) begin
         for (int p = 0; p < 9; p++) prod_ff[p] <= prod_in[p];
      end
      if (out_rdy) begin
         rx_ff   <= sat[0];
         ry_ff   <= sat[1];
         rz_ff   <= sat[2];
         clip_ff <= |clip;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_rotated_x = rx_ff;
   assign rsp_rotated_y = ry_ff;
   assign rsp_rotated_z = rz_ff;
   assign rsp_clipped   = clip_ff;

endmodule

// ----- rtl/ezpr_cordic_cell.sv -----
// ---------------------------------------------------------------------------
// CORDIC cell
// One rotation stage for the three angle lanes, with its own pipeline register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ezpr_cordic_cell import ezpr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [STAGE_IDX_W-1:0] stage_idx,
   input  logic                   in_valid,
   input  cordic_item_type        in_item,
   output logic                   in_ready,
   output logic                   out_valid,
   output cordic_item_type        out_item,
   input  logic                   out_ready
);

   logic                      valid_ff;
   cordic_item_type           item_ff, item_in;
   logic signed [PHASE_W-1:0] atan_val;
   logic signed [TRIG_W-1:0]  dx [3];
   logic signed [TRIG_W-1:0]  dy [3];

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign atan_val  = atan_turn(stage_idx);

   always_comb begin
      item_in = in_item;
      for (int l = 0; l < 3; l++) begin
         dx[l] = in_item.lane[l].y >>> stage_idx;
         dy[l] = in_item.lane[l].x >>> stage_idx;
         if (!in_item.lane[l].z[PHASE_W-1]) begin
            item_in.lane[l].x = in_item.lane[l].x - dx[l];
            item_in.lane[l].y = in_item.lane[l].y + dy[l];
            item_in.lane[l].z = in_item.lane[l].z - atan_val;
         end else begin
            item_in.lane[l].x = in_item.lane[l].x + dx[l];
            item_in.lane[l].y = in_item.lane[l].y - dy[l];
            item_in.lane[l].z = in_item.lane[l].z + atan_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- rtl/ezpr_matrix.sv -----
// ---------------------------------------------------------------------------
// Rotation matrix builder
// Turns the CORDIC results into sines and cosines and forms the ZYX matrix.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ezpr_matrix import ezpr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  cordic_item_type in_item,
   output logic            in_ready,
   output logic            out_valid,
   output matrix_item_type out_item,
   input  logic            out_ready
);

   typedef struct packed {
      logic signed [TRIG_W-1:0]  ca, sa, cb, sb, cc, sc;
      logic signed [COORD_W-1:0] px, py, pz;
   } trig_type;

   typedef struct packed {
      logic signed [63:0]        sbsc, sbcc, cacb, sacb, cbsc, cbcc, sacc, sasc, cacc, casc;
      logic signed [TRIG_W-1:0]  ca, sa, sb;
      logic signed [COORD_W-1:0] px, py, pz;
   } prod_type;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] sbsc, sbcc, cacb, sacb, cbsc, cbcc, sacc, sasc, cacc, casc;
      logic signed [TRIG_W-1:0]  ca, sa, sb;
      logic signed [COORD_W-1:0] px, py, pz;
   } round_type;

   typedef struct packed {
      logic signed [63:0]        ca_sbsc, sa_sbsc, ca_sbcc, sa_sbcc;
      logic signed [ENTRY_W-1:0] cacb, sacb, cbsc, cbcc, sacc, sasc, cacc, casc;
      logic signed [TRIG_W-1:0]  sb;
      logic signed [COORD_W-1:0] px, py, pz;
   } triple_type;

   logic            valid_ff [4];
   logic            rdy [4];
   trig_type        trig_ff, trig_in;
   prod_type        prod_ff, prod_in;
   round_type       rnd_ff, rnd_in;
   triple_type      tri_ff, tri_in;
   matrix_item_type mat_ff, mat_in;
   logic            mat_valid_ff;
   logic            mat_rdy;

   assign mat_rdy   = !mat_valid_ff || out_ready;
   assign rdy[3]    = !valid_ff[3] || mat_rdy;
   assign rdy[2]    = !valid_ff[2] || rdy[3];
   assign rdy[1]    = !valid_ff[1] || rdy[2];
   assign rdy[0]    = !valid_ff[0] || rdy[1];
   assign in_ready  = rdy[0];
   assign out_valid = mat_valid_ff;
   assign out_item  = mat_ff;

   always_comb begin
      trig_in.ca = in_item.flip[0] ? -in_item.lane[0].x : in_item.lane[0].x;
      trig_in.sa = in_item.flip[0] ? -in_item.lane[0].y : in_item.lane[0].y;
      trig_in.cb = in_item.flip[1] ? -in_item.lane[1].x : in_item.lane[1].x;
      trig_in.sb = in_item.flip[1] ? -in_item.lane[1].y : in_item.lane[1].y;
      trig_in.cc = in_item.flip[2] ? -in_item.lane[2].x : in_item.lane[2].x;
      trig_in.sc = in_item.flip[2] ? -in_item.lane[2].y : in_item.lane[2].y;
      trig_in.px = in_item.px;
      trig_in.py = in_item.py;
      trig_in.pz = in_item.pz;

      prod_in.sbsc = trig_ff.sb * trig_ff.sc;
      prod_in.sbcc = trig_ff.sb * trig_ff.cc;
      prod_in.cacb = trig_ff.ca * trig_ff.cb;
      prod_in.sacb = trig_ff.sa * trig_ff.cb;
      prod_in.cbsc = trig_ff.cb * trig_ff.sc;
      prod_in.cbcc = trig_ff.cb * trig_ff.cc;
      prod_in.sacc = trig_ff.sa * trig_ff.cc;
      prod_in.sasc = trig_ff.sa * trig_ff.sc;
      prod_in.cacc = trig_ff.ca * trig_ff.cc;
      prod_in.casc = trig_ff.ca * trig_ff.sc;
      prod_in.ca   = trig_ff.ca;
      prod_in.sa   = trig_ff.sa;
      prod_in.sb   = trig_ff.sb;
      prod_in.px   = trig_ff.px;
      prod_in.py   = trig_ff.py;
      prod_in.pz   = trig_ff.pz;

      rnd_in.sbsc = round_q30(prod_ff.sbsc);
      rnd_in.sbcc = round_q30(prod_ff.sbcc);
      rnd_in.cacb = round_q30(prod_ff.cacb);
      rnd_in.sacb = round_q30(prod_ff.sacb);
      rnd_in.cbsc = round_q30(prod_ff.cbsc);
      rnd_in.cbcc = round_q30(prod_ff.cbcc);
      rnd_in.sacc = round_q30(prod_ff.sacc);
      rnd_in.sasc = round_q30(prod_ff.sasc);
      rnd_in.cacc = round_q30(prod_ff.cacc);
      rnd_in.casc = round_q30(prod_ff.casc);
      rnd_in.ca   = prod_ff.ca;
      rnd_in.sa   = prod_ff.sa;
      rnd_in.sb   = prod_ff.sb;
      rnd_in.px   = prod_ff.px;
      rnd_in.py   = prod_ff.py;
      rnd_in.pz   = prod_ff.pz;

      tri_in.ca_sbsc = rnd_ff.ca * rnd_ff.sbsc;
      tri_in.sa_sbsc = rnd_ff.sa * rnd_ff.sbsc;
      tri_in.ca_sbcc = rnd_ff.ca * rnd_ff.sbcc;
      tri_in.sa_sbcc = rnd_ff.sa * rnd_ff.sbcc;
      tri_in.cacb    = rnd_ff.cacb;
      tri_in.sacb    = rnd_ff.sacb;
      tri_in.cbsc    = rnd_ff.cbsc;
      tri_in.cbcc    = rnd_ff.cbcc;
      tri_in.sacc    = rnd_ff.sacc;
      tri_in.sasc    = rnd_ff.sasc;
      tri_in.cacc    = rnd_ff.cacc;
      tri_in.casc    = rnd_ff.casc;
      tri_in.sb      = rnd_ff.sb;
      tri_in.px      = rnd_ff.px;
      tri_in.py      = rnd_ff.py;
      tri_in.pz      = rnd_ff.pz;

      mat_in.m00 = tri_ff.cacb;
      mat_in.m01 = round_q30(tri_ff.ca_sbsc) - tri_ff.sacc;
      mat_in.m02 = round_q30(tri_ff.ca_sbcc) + tri_ff.sasc;
      mat_in.m10 = tri_ff.sacb;
      mat_in.m11 = round_q30(tri_ff.sa_sbsc) + tri_ff.cacc;
      mat_in.m12 = round_q30(tri_ff.sa_sbcc) - tri_ff.casc;
      mat_in.m20 = -ENTRY_W'(tri_ff.sb);
      mat_in.m21 = tri_ff.cbsc;
      mat_in.m22 = tri_ff.cbcc;
      mat_in.px  = tri_ff.px;
      mat_in.py  = tri_ff.py;
      mat_in.pz  = tri_ff.pz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0]  <= 1'b0;
         valid_ff[1]  <= 1'b0;
         valid_ff[2]  <= 1'b0;
         valid_ff[3]  <= 1'b0;
         mat_valid_ff <= 1'b0;
      end else begin
         if (rdy[0]) valid_ff[0] <= in_valid;
         if (rdy[1]) valid_ff[1] <= valid_ff[0];
         if (rdy[2]) valid_ff[2] <= valid_ff[1];
         if (rdy[3]) valid_ff[3] <= valid_ff[2];
         if (mat_rdy) mat_valid_ff <= valid_ff[3];
      end
      if (rdy[0]) trig_ff <= trig_in;
      if (rdy[1]) prod_ff <= prod_in;
      if (rdy[2]) rnd_ff <= rnd_in;
      if (rdy[3]) tri_ff <= tri_in;
      if (mat_rdy) mat_ff <= mat_in;
   end

endmodule

// ----- rtl/ezpr_checker.sv -----
// ---------------------------------------------------------------------------
// Euler ZYX point rotator checker
// Port-level assertions on the rotator, attached to the top level by bind.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "euler_zyx_point_rotator_macros.svh"

module ezpr_checker import ezpr_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic signed [COORD_W-1:0] req_point_x,
   input logic signed [COORD_W-1:0] req_point_y,
   input logic signed [COORD_W-1:0] req_point_z,
   input logic signed [15:0]        req_yaw_angle,
   input logic signed [15:0]        req_pitch_angle,
   input logic signed [15:0]        req_roll_angle,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [COORD_W-1:0] rsp_rotated_x,
   input logic signed [COORD_W-1:0] rsp_rotated_y,
   input logic signed [COORD_W-1:0] rsp_rotated_z,
   input logic                      rsp_clipped
);

   `EZPR_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid)
   `EZPR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rotated_x) && $stable(rsp_rotated_y) && $stable(rsp_rotated_z) && $stable(rsp_clipped))
   `EZPR_ASSERT(a_full_only_when_stalled, clock, reset, !req_ready |-> rsp_valid && !rsp_ready)
   `EZPR_ASSERT(a_clip_at_limit, clock, reset, rsp_valid && rsp_clipped |-> rsp_rotated_x == COORD_MAX || rsp_rotated_x == COORD_MIN || rsp_rotated_y == COORD_MAX || rsp_rotated_y == COORD_MIN || rsp_rotated_z == COORD_MAX || rsp_rotated_z == COORD_MIN)

endmodule

bind euler_zyx_point_rotator ezpr_checker u_checker (.*);

// ----- dv/euler_zyx_point_rotator_checker.sv -----
// ---------------------------------------------------------------------------
// Euler ZYX point rotator checker
// Watches both channels, computes the expected rotated point for every
// accepted request and compares each accepted response field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module euler_zyx_point_rotator_checker import ezpr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic signed [COORD_W-1:0] req_point_z,
   input  logic signed [15:0]        req_yaw_angle,
   input  logic signed [15:0]        req_pitch_angle,
   input  logic signed [15:0]        req_roll_angle,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [COORD_W-1:0] rsp_rotated_x,
   input  logic signed [COORD_W-1:0] rsp_rotated_y,
   input  logic signed [COORD_W-1:0] rsp_rotated_z,
   input  logic                      rsp_clipped,
   output int                        mismatch_count,
   output int                        pending_points
);

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      clip;
   } rotated_point_type;

   localparam longint TRIG_GAIN = 64'sd652032874;
   localparam longint TRIG_HALF = 64'sd536870912;

   longint arctan_step [TABLE_LEN] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
      64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

   rotated_point_type expected_points[$];

   function automatic longint fixed_round(longint v);
      return (v + TRIG_HALF) >>> 30;
   endfunction

   task automatic angle_sincos(input logic [15:0] angle, output longint c, output longint s);
      logic [31:0] phase;
      logic        flip;
      longint      x, y, z, dx, dy;
      phase = {angle, 16'h0000};
      flip  = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
      x = TRIG_GAIN;
      y = 0;
      if (flip)
         phase = phase + 32'h80000000;
      z = longint'($signed(phase));
      for (int i = 0; i < NUM_STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - arctan_step[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + arctan_step[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic logic signed [COORD_W-1:0] clamp_coord(longint v, ref logic clip);
      if (v > 64'sd8388607) begin
         clip = 1'b1;
         return 24'sh7FFFFF;
      end
      if (v < -64'sd8388608) begin
         clip = 1'b1;
         return 24'sh800000;
      end
      return v[COORD_W-1:0];
   endfunction

   task automatic predict_rotation(output rotated_point_type r);
      longint ca, sa, cb, sb, cc, sc, sbsc, sbcc;
      longint m[3][3];
      longint p[3];
      longint acc;
      logic   clip;
      logic signed [COORD_W-1:0] o[3];
      angle_sincos(req_yaw_angle, ca, sa);
      angle_sincos(req_pitch_angle, cb, sb);
      angle_sincos(req_roll_angle, cc, sc);
      p[0] = req_point_x;
      p[1] = req_point_y;
      p[2] = req_point_z;
      sbsc = fixed_round(sb * sc);
      sbcc = fixed_round(sb * cc);
      m[0][0] = fixed_round(ca * cb);
      m[0][1] = fixed_round(ca * sbsc) - fixed_round(sa * cc);
      m[0][2] = fixed_round(ca * sbcc) + fixed_round(sa * sc);
      m[1][0] = fixed_round(sa * cb);
      m[1][1] = fixed_round(sa * sbsc) + fixed_round(ca * cc);
      m[1][2] = fixed_round(sa * sbcc) - fixed_round(ca * sc);
      m[2][0] = -sb;
      m[2][1] = fixed_round(cb * sc);
      m[2][2] = fixed_round(cb * cc);
      clip = 1'b0;
      for (int k = 0; k < 3; k++) begin
         acc = m[k][0] * p[0] + m[k][1] * p[1] + m[k][2] * p[2];
         o[k] = clamp_coord(fixed_round(acc), clip);
      end
      r = '{x: o[0], y: o[1], z: o[2], clip: clip};
   endtask

   always @(posedge clock) begin
      rotated_point_type want, got;
      if (reset) begin
         mismatch_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_rotation(want);
            expected_points.insert(expected_points.size(), want);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{x: rsp_rotated_x, y: rsp_rotated_y, z: rsp_rotated_z, clip: rsp_clipped};
            if (expected_points.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("Unexpected response transaction: %0d %0d %0d clip %0d",
                           got.x, got.y, got.z, got.clip);
            end else begin
               want = expected_points.pop_front();
               if (got !== want) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("Mismatch: expected %0d %0d %0d clip %0d, got %0d %0d %0d clip %0d",
                              want.x, want.y, want.z, want.clip,
                              got.x, got.y, got.z, got.clip);
               end
            end
         end
      end
      pending_points <= expected_points.size();
   end

endmodule

// ----- dv/euler_zyx_point_rotator_tb.sv -----
// ---------------------------------------------------------------------------
// Euler ZYX point rotator testbench
// Drives directed and random points and angles through the rotator with
// random idle bursts on both channels; the checker gives the verdict input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module euler_zyx_point_rotator_tb import ezpr_pkg::*;;

   localparam int NUM_RANDOM = 1200;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [COORD_W-1:0] req_point_x, req_point_y, req_point_z;
   logic signed [15:0] req_yaw_angle, req_pitch_angle, req_roll_angle;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [COORD_W-1:0] rsp_rotated_x, rsp_rotated_y, rsp_rotated_z;
   logic rsp_clipped;
   int   mismatch_count;
   int   pending_points;
   bit   quiet_phase;

   euler_zyx_point_rotator dut (.*);

   euler_zyx_point_rotator_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("[euler_zyx_point_rotator] ERROR");
      $finish;
   end

   // Receiver stalls in random bursts until the quiet phase.
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(0, 5))
         0:       return 24'h7FFFFF;
         1:       return 24'h800000;
         2:       return 24'($urandom_range(0, 8191) - 4096);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(0, 7))
         0:       return {2'($urandom_range(0, 3)), 14'h0000};
         1:       return {2'($urandom_range(0, 3)), 14'h0000} - 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_point(input logic [23:0] x, y, z, input logic [15:0] a, b, c);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_point_x     <= x;
      req_point_y     <= y;
      req_point_z     <= z;
      req_yaw_angle   <= a;
      req_pitch_angle <= b;
      req_roll_angle  <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   initial begin
      logic [15:0] angle_set[8];
      angle_set = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF, 16'h8001, 16'h3FFF,
                    16'hFFFF};
      quiet_phase     = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_point_x     = '0;
      req_point_y     = '0;
      req_point_z     = '0;
      req_yaw_angle   = '0;
      req_pitch_angle = '0;
      req_roll_angle  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 8; i++)
         send_point(24'h001000, 24'h002000, 24'h003000, angle_set[i], angle_set[(i + 3) % 8],
                    angle_set[(i + 5) % 8]);
      send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h2000, 16'h2000, 16'h2000);
      send_point(24'h800000, 24'h800000, 24'h800000, 16'hE000, 16'hE000, 16'hE000);
      send_point(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h8000, 16'h8000, 16'h8000);
      send_point(24'h000000, 24'h000000, 24'h000000, 16'h1234, 16'h5678, 16'h9ABC);
      send_point(24'h800000, 24'h7FFFFF, 24'h000001, 16'h7FFF, 16'h8000, 16'h0001);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_points != 0) @(posedge clock);
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == NUM_RANDOM - 150)
            quiet_phase = 1'b1;
         send_point(rand_coord(), rand_coord(), rand_coord(), rand_angle(), rand_angle(),
                    rand_angle());
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_points != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("[euler_zyx_point_rotator] OK");
      else
         $display("[euler_zyx_point_rotator] ERROR");
      $finish;
   end

endmodule
